[rtl/sbmq_pkg.sv]
// Package for the shared buffer multi queue: default sizes, codes and
// the request and response transfer types. No dependencies.
package sbmq_pkg;

  localparam int SBMQ_STORE_DEPTH = 16;
  localparam int SBMQ_QUEUE_COUNT = 4;
  localparam int SBMQ_DATA_BITS   = 32;

  typedef enum logic [0:0] {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [1:0]         queue_id;
    logic signed [31:0] data_in;
  } sbmq_req_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    status_t            status;
  } sbmq_rsp_t;

endpackage

[rtl/sbmq_ram.sv]
// Generic single write port RAM with registered read for the multi queue.
// Depends on nothing.
module sbmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/shared_buffer_multi_queue.sv]
// Top level of the shared buffer multi queue: queues linked through one
// link RAM and one data RAM, both sbmq_ram instances. Uses sbmq_pkg.
//
//   channel   | ports                 | transfer
//   ----------+-----------------------+---------------------------------
//   request   | start, busy, request  | edge with start high, busy low
//   response  | done, response       | edge ending the cycle done is high
//
// For each item the accept edge issues the RAM reads and the next edge
// updates the queue state and loads the response; busy is high in between,
// so a new item is taken only once the last is through. The RAM
// read-then-write sets this. After reset busy stays high while the link
// RAM is filled with the initial free chain. The receiver cannot stall.
module shared_buffer_multi_queue
  import sbmq_pkg::*;
#(
  parameter int STORE_DEPTH = SBMQ_STORE_DEPTH,
  parameter int QUEUE_COUNT = SBMQ_QUEUE_COUNT,
  parameter int DATA_BITS   = SBMQ_DATA_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  sbmq_req_t request,
  output logic      done,
  output sbmq_rsp_t response
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(STORE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STORE_DEPTH);

  logic [AW-1:0] head_index [QUEUE_COUNT];
  logic [AW-1:0] tail_index [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] queue_nonempty;
  logic [AW-1:0] free_head;
  logic [CW-1:0] free_count;

  logic          init_active;
  logic [AW-1:0] init_cnt;

  logic      exec_valid;
  sbmq_req_t req;

  logic           accept;
  logic           in_q_ok;
  logic [QW-1:0]  in_q;
  logic [AW-1:0]  link_raddr;
  logic [AW-1:0]  data_raddr;
  logic [AW-1:0]  link_rdata;
  logic [DATA_BITS-1:0] data_rdata;

  logic          q_ok;
  logic [QW-1:0] q;
  logic          enq_ok;
  logic          deq_ok;
  logic [AW-1:0] q_head;
  logic [AW-1:0] q_tail;

  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [AW-1:0] link_wdata;
  logic          data_we;
  logic [DATA_BITS-1:0] data_wdata;
  logic [63:0]   data_wide;
  sbmq_rsp_t     response_next;

  assign busy   = init_active | exec_valid;
  assign accept = start & ~busy;

  assign in_q_ok = 32'(request.queue_id) < 32'(QUEUE_COUNT);
  assign in_q    = in_q_ok ? QW'(request.queue_id) : '0;
  assign data_raddr = head_index[in_q];
  assign link_raddr = (request.cmd == CMD_DEQ) ? head_index[in_q] : free_head;

  assign q_ok   = 32'(req.queue_id) < 32'(QUEUE_COUNT);
  assign q      = q_ok ? QW'(req.queue_id) : '0;
  assign q_head = head_index[q];
  assign q_tail = tail_index[q];
  assign enq_ok = exec_valid && req.cmd == CMD_ENQ && q_ok && free_count != '0;
  assign deq_ok = exec_valid && req.cmd == CMD_DEQ && q_ok && queue_nonempty[q];

  always_comb begin
    if (init_active) begin
      link_we    = 1'b1;
      link_waddr = init_cnt;
      link_wdata = (init_cnt == LAST_SLOT) ? '0 : init_cnt + 1'b1;
    end else if (deq_ok) begin
      link_we    = 1'b1;
      link_waddr = q_head;
      link_wdata = free_head;
    end else begin
      link_we    = enq_ok & queue_nonempty[q];
      link_waddr = q_tail;
      link_wdata = free_head;
    end
  end

  assign data_we    = enq_ok;
  assign data_wdata = DATA_BITS'(req.data_in);
  assign data_wide  = 64'(data_rdata);

  always_comb begin
    response_next.data_out = '0;
    response_next.status   = ST_OK;
    case (req.cmd)
      CMD_ENQ: begin
        if (!enq_ok) begin
          response_next.status = ST_FULL;
        end
      end
      CMD_DEQ: begin
        if (deq_ok) begin
          response_next.data_out = data_wide[31:0];
        end else begin
          response_next.status = ST_EMPTY;
        end
      end
      default: begin
        response_next.status = ST_OK;
      end
    endcase
  end

  sbmq_ram #(.WIDTH(AW), .DEPTH(STORE_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  sbmq_ram #(.WIDTH(DATA_BITS), .DEPTH(STORE_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (free_head),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      init_active    <= 1'b1;
      init_cnt       <= '0;
      exec_valid     <= 1'b0;
      done           <= 1'b0;
      queue_nonempty <= '0;
      free_head      <= '0;
      free_count     <= FULL_COUNT;
    end else begin
      if (init_active) begin
        init_cnt <= init_cnt + 1'b1;
        if (init_cnt == LAST_SLOT) begin
          init_active <= 1'b0;
        end
      end
      exec_valid <= accept;
      done       <= exec_valid;
      if (enq_ok) begin
        free_head         <= link_rdata;
        free_count        <= free_count - 1'b1;
        queue_nonempty[q] <= 1'b1;
      end
      if (deq_ok) begin
        free_head <= q_head;
        if (free_count < FULL_COUNT) begin
          free_count <= free_count + 1'b1;
        end
        if (q_head == q_tail) begin
          queue_nonempty[q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
    end
    if (exec_valid) begin
      response <= response_next;
    end
    if (enq_ok) begin
      tail_index[q] <= free_head;
      if (!queue_nonempty[q]) begin
        head_index[q] <= free_head;
      end
    end
    if (deq_ok && q_head != q_tail) begin
      head_index[q] <= link_rdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= FULL_COUNT)
    else $error("free count above store depth");

  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted item gave no result");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && response.status != ST_OK |-> response.data_out == '0)
    else $error("error result carries data");

  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    init_active |-> !done && !exec_valid)
    else $error("item processed during link fill");

endmodule

[bench/tb.sv]
// Testbench for shared_buffer_multi_queue. It sends enqueue and dequeue commands,
// predicts each response from a shadow copy of the linked queues and free list,
// and checks every response transfer. Depends on sbmq_pkg and the RTL.
module tb
  import sbmq_pkg::*;
();

  localparam int DEPTH       = SBMQ_STORE_DEPTH;
  localparam int QUEUES      = SBMQ_QUEUE_COUNT;
  localparam int STALL_LIMIT = 1000;

  logic      clk     = 1'b0;
  logic      rst     = 1'b1;
  logic      start   = 1'b0;
  sbmq_req_t request = '0;
  logic      busy;
  logic      done;
  sbmq_rsp_t response;

  logic [3:0]         head_ptr  [QUEUES];
  logic [3:0]         tail_ptr  [QUEUES];
  logic               live      [QUEUES];
  logic [3:0]         next_ptr  [DEPTH];
  logic signed [31:0] slot_data [DEPTH];
  logic [3:0]         free_ptr;
  logic [4:0]         free_left;

  sbmq_rsp_t due_responses [$];
  int        fail_count   = 0;
  int        stall_cycles = 0;
  bit        gaps_on      = 1'b1;

  shared_buffer_multi_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sbmq_rsp_t apply_queue_op(sbmq_req_t req);
    sbmq_rsp_t  rsp;
    logic [3:0] slot;
    int         q;
    rsp.data_out = '0;
    rsp.status   = ST_OK;
    q = int'(req.queue_id);
    if (req.cmd == CMD_ENQ) begin
      if (q >= QUEUES || free_left == 5'd0) begin
        rsp.status = ST_FULL;
      end else begin
        slot      = free_ptr;
        free_ptr  = next_ptr[slot];
        free_left = free_left - 5'd1;
        if (live[q]) begin
          next_ptr[tail_ptr[q]] = slot;
        end else begin
          head_ptr[q] = slot;
        end
        tail_ptr[q]     = slot;
        live[q]         = 1'b1;
        slot_data[slot] = req.data_in;
      end
    end else begin
      if (q >= QUEUES || !live[q]) begin
        rsp.status = ST_EMPTY;
      end else begin
        slot = head_ptr[q];
        if (slot == tail_ptr[q]) begin
          live[q] = 1'b0;
        end else begin
          head_ptr[q] = next_ptr[slot];
        end
        next_ptr[slot] = free_ptr;
        free_ptr       = slot;
        if (free_left < 5'(DEPTH)) begin
          free_left = free_left + 5'd1;
        end
        rsp.data_out = slot_data[slot];
      end
    end
    return rsp;
  endfunction

  task automatic send_op(cmd_t op, logic [1:0] qid, logic signed [31:0] value);
    sbmq_req_t req;
    req.cmd      = op;
    req.queue_id = qid;
    req.data_in  = value;
    request <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    due_responses.push_back(apply_queue_op(req));
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    send_op(CMD_DEQ, 2'd0, 32'sd0);
    send_op(CMD_ENQ, 2'd0, 32'h8000_0000);
    send_op(CMD_ENQ, 2'd1, 32'h7fff_ffff);
    send_op(CMD_ENQ, 2'd2, 32'hffff_ffff);
    send_op(CMD_ENQ, 2'd3, 32'h0000_0000);
    // last element leaves, then the queue reads empty
    send_op(CMD_DEQ, 2'd3, $urandom);
    send_op(CMD_DEQ, 2'd3, 32'sd0);
    for (int i = 0; i < 13; i++) begin
      send_op(CMD_ENQ, 2'(i), $urandom);
    end
    // store full
    send_op(CMD_ENQ, 2'd1, 32'h5a5a_a5a5);
    send_op(CMD_DEQ, 2'd0, 32'hffff_ffff);
    send_op(CMD_ENQ, 2'd3, 32'h1234_5678);
    send_op(CMD_ENQ, 2'd2, 32'h0bad_f00d);
  endtask

  task automatic test_random_traffic(int count);
    bit                 fill_bias;
    logic signed [31:0] value;
    logic [1:0]         qid;
    fill_bias = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        fill_bias = 1'($urandom_range(0, 1));
      end
      case ($urandom_range(0, 9))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7fff_ffff;
        2:       value = 32'h0000_0000;
        3:       value = 32'hffff_ffff;
        default: value = $urandom;
      endcase
      qid = 2'($urandom_range(0, QUEUES - 1));
      if ($urandom_range(0, 9) < (fill_bias ? 7 : 3)) begin
        send_op(CMD_ENQ, qid, value);
      end else begin
        send_op(CMD_DEQ, qid, value);
      end
    end
  endtask

  task automatic test_back_to_back(int count);
    gaps_on = 1'b0;
    test_random_traffic(count);
  endtask

  always @(posedge clk) begin
    sbmq_rsp_t want;
    if (!rst && done === 1'b1) begin
      if (due_responses.size() == 0) begin
        $error("unexpected response: data_out %0h status %0d",
               response.data_out, response.status);
        fail_count++;
      end else begin
        want = due_responses.pop_front();
        if (response.data_out !== want.data_out) begin
          $error("data_out: expected %0h, got %0h", want.data_out, response.data_out);
          fail_count++;
        end
        if (response.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, response.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int q = 0; q < QUEUES; q++) begin
      head_ptr[q] = '0;
      tail_ptr[q] = '0;
      live[q]     = 1'b0;
    end
    for (int i = 0; i < DEPTH; i++) begin
      next_ptr[i]  = 4'(i + 1);
      slot_data[i] = '0;
    end
    free_ptr  = '0;
    free_left = 5'(DEPTH);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(380);
    test_back_to_back(100);
    start <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
